/* design/rmst_pkg.sv */
// Shared types and constants for the range-minimum segment tree core.
package rmst_pkg;

  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int DATA_W = 32;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  // Operation codes carried in s_tuser
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // Register byte-address word select
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LEAF,
    ST_UPD_CLIMB,
    ST_Q_LEFT,
    ST_Q_RIGHT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic upd_leaf;
    logic upd_climb;
    logic q_left;
    logic q_right;
    logic resp_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_query;
    logic bad;
    logic empty;
    logic upd_top;
    logic q_more;
    logic out_free;
  } dp_stat_t;

endpackage

/* design/rmst_ctrl.sv */
// Controller state machine for the range-minimum segment tree core.
module rmst_ctrl
  import rmst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          priority if (stat.bad) state_next = ST_RESP;
          else if (!stat.is_query) state_next = ST_UPD_LEAF;
          else if (stat.empty) state_next = ST_RESP;
          else state_next = ST_Q_LEFT;
        end
      end
      ST_UPD_LEAF:  state_next = ST_UPD_CLIMB;
      ST_UPD_CLIMB: begin
        if (stat.upd_top) state_next = ST_RESP;
      end
      ST_Q_LEFT:    state_next = stat.q_more ? ST_Q_RIGHT : ST_RESP;
      ST_Q_RIGHT:   state_next = ST_Q_LEFT;
      ST_RESP: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    s_tready      = 1'b0;
    unique case (state)
      ST_CLEAR:     cmd.clr_step = 1'b1;
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_UPD_LEAF:  cmd.upd_leaf = 1'b1;
      ST_UPD_CLIMB: cmd.upd_climb = 1'b1;
      ST_Q_LEFT:    cmd.q_left = 1'b1;
      ST_Q_RIGHT:   cmd.q_right = 1'b1;
      ST_RESP:      cmd.resp_load = stat.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

/* design/rmst_dp.sv */
// Datapath for the range-minimum segment tree core: tree memory, walk registers, output register.
module rmst_dp
  import rmst_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CNT_W-1:0]         element_count,
  input  logic                     func,
  input  logic [IDX_W-1:0]         first_index,
  input  logic [IDX_W-1:0]         last_index,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic                     m_tready,
  output logic                     m_tvalid,
  output logic signed [DATA_W-1:0] min_value,
  output logic                     status,
  input  ctrl_cmd_t                cmd,
  output dp_stat_t                 stat
);

  localparam int LEAF_W = $clog2(MAX_ELEMENTS);
  localparam int LEAVES = 1 << LEAF_W;
  localparam int ADDR_W = LEAF_W + 1;
  localparam int QW     = ADDR_W + 1;
  localparam int DEPTH  = 2 * LEAVES;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] mem_rdata;
  logic                     mem_we;
  logic                     mem_re;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [ADDR_W-1:0]        mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata;

  logic [ADDR_W-1:0]        clr_cnt;
  logic [QW-1:0]            lo;
  logic [QW-1:0]            hi;
  logic signed [DATA_W-1:0] val;
  logic signed [DATA_W-1:0] acc;
  logic                     err;
  logic                     rd_pend;

  logic [31:0]              cnt_eff;
  logic [31:0]              last_c;
  logic [31:0]              lo_init;
  logic [31:0]              hi_init;
  logic [QW-1:0]            parent;
  logic signed [DATA_W-1:0] pmin;
  logic                     q_more;
  logic                     q_rd_left;
  logic                     q_rd_right;

  // Clamp the element count and last index of the incoming request; form the walk bounds
  always_comb begin
    cnt_eff = (32'(element_count) > 32'(MAX_ELEMENTS)) ? 32'(MAX_ELEMENTS)
                                                       : 32'(element_count);
    last_c  = (32'(last_index) > cnt_eff - 32'd1) ? cnt_eff - 32'd1 : 32'(last_index);
    lo_init = 32'(LEAVES) + 32'(first_index);
    hi_init = 32'(LEAVES) + last_c + 32'd1;
  end

  assign parent     = lo >> 1;
  assign pmin       = (val < mem_rdata) ? val : mem_rdata;
  assign q_more     = lo < hi;
  assign q_rd_left  = cmd.q_left && q_more && lo[0];
  assign q_rd_right = cmd.q_right && hi[0];

  always_comb begin
    stat.clr_done = &clr_cnt;
    stat.is_query = (func == FUNC_QUERY);
    stat.bad      = 32'(first_index) >= cnt_eff;
    stat.empty    = last_c < 32'(first_index);
    stat.upd_top  = (parent == QW'(1));
    stat.q_more   = q_more;
    stat.out_free = !m_tvalid || m_tready;
  end

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = lo[ADDR_W-1:0];
    mem_raddr = lo[ADDR_W-1:0];
    mem_wdata = val;
    priority if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = INT_MAX;
    end else if (cmd.upd_leaf) begin
      mem_we    = 1'b1;
      mem_re    = 1'b1;
      mem_raddr = lo[ADDR_W-1:0] ^ ADDR_W'(1);
    end else if (cmd.upd_climb) begin
      mem_we    = 1'b1;
      mem_waddr = parent[ADDR_W-1:0];
      mem_wdata = pmin;
      mem_re    = 1'b1;
      mem_raddr = parent[ADDR_W-1:0] ^ ADDR_W'(1);
    end else if (q_rd_left) begin
      mem_re    = 1'b1;
    end else if (q_rd_right) begin
      mem_re    = 1'b1;
      mem_raddr = hi[ADDR_W-1:0] - ADDR_W'(1);
    end else begin
      mem_re    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + ADDR_W'(1);
      rd_pend <= q_rd_left || q_rd_right;
      if (cmd.resp_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lo  <= lo_init[QW-1:0];
      hi  <= hi_init[QW-1:0];
      val <= new_value;
      acc <= (func == FUNC_QUERY) ? INT_MAX : '0;
      err <= stat.bad;
    end else begin
      if (rd_pend && mem_rdata < acc) acc <= mem_rdata;
      if (cmd.upd_climb) begin
        lo  <= parent;
        val <= pmin;
      end
      if (cmd.q_left && q_more) lo <= lo + QW'(lo[0]);
      if (cmd.q_right) begin
        lo <= lo >> 1;
        hi <= hi >> 1;
      end
    end
    if (cmd.resp_load) begin
      min_value <= acc;
      status    <= err;
    end
  end

endmodule

/* design/range_minimum_segment_tree_core.sv */
// Top level of the range-minimum segment tree core: stream ports, register port, wiring.
//
// Keeps minima of signed 32-bit elements in a power-of-two segment tree held in one
// memory of 2*2^ceil(log2(MAX_ELEMENTS)) words (one write and one registered read per
// cycle). After reset a clearing pass writes the largest value to every word, one word
// a cycle; no request is taken during the pass (register writes still are). A request
// is an update (s_tuser = 0) or a range minimum query (s_tuser = 1). An update writes
// its leaf and climbs one level per cycle, reading the sibling and writing the parent.
// A query walks the range bottom-up with up to two memory reads per level, one in the
// Q_LEFT state and one in the Q_RIGHT state. Requests that fail the index check, and
// empty queries, go straight to the response state. The single memory read port is
// why a query level takes both states. One request is in the tree at a time; a new one
// is taken while the previous result still waits in the output register.
module range_minimum_segment_tree_core
  import rmst_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
)
(
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // [9:0] first_index, [19:10] last_index, [51:20] new_value
  input  logic        s_tuser,   // [0] func
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] min_value
  output logic        m_tuser,   // [0] status
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CNT_W-1:0]         element_count;
  logic signed [DATA_W-1:0] min_value;
  ctrl_cmd_t                cmd;
  dp_stat_t                 stat;

  assign pready = 1'b1;

  // Hold the element count; drop writes to words beyond the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ELEMENT_COUNT) begin
      element_count <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? 32'(element_count) : 32'd0;

  rmst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmst_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .element_count (element_count),
    .func          (s_tuser),
    .first_index   (s_tdata[9:0]),
    .last_index    (s_tdata[19:10]),
    .new_value     (s_tdata[51:20]),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .min_value     (min_value),
    .status        (m_tuser),
    .cmd           (cmd),
    .stat          (stat)
  );

  assign m_tdata = min_value;

endmodule
